// ----- design/amao_pkg.sv -----
// Package for the angle moving-average offset unit: field widths, register
// indexes, the configuration bundle and the running-sum width helper.
// No dependencies.
package amao_pkg;

    localparam int RAW_W      = 16;
    localparam int ANGLE_W    = 14;
    localparam int VAL_W      = 15;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam int WINDOW_DEFAULT = 8;
    localparam int WINDOW_MIN     = 1;
    localparam int WINDOW_MAX     = 64;

    // Largest value one window entry can hold.
    localparam int ENTRY_MAX = (1 << VAL_W) - 1;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FULLSCALE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP      = CFG_IDX_W'(3);

    localparam logic [VAL_W-1:0]   FULLSCALE_RESET = VAL_W'(16384);
    localparam logic [VAL_W-1:0]   WRAP_RESET      = VAL_W'(16384);

    typedef struct packed {
        logic               reverse_direction;
        logic [VAL_W-1:0]   full_scale;
        logic [ANGLE_W-1:0] angle_offset;
        logic [VAL_W-1:0]   wrap_modulo;
    } t_cfg;

    // Bits needed to hold the sum of a full window.
    function automatic int sum_width(input int window);
        return $clog2(window * ENTRY_MAX + 1);
    endfunction

endpackage

// ----- design/amao_window.sv -----
// Sample window shift line and running sum for the angle unit.
// Depends on amao_pkg.
module amao_window #(
    parameter int WINDOW = amao_pkg::WINDOW_DEFAULT,
    localparam int SW    = amao_pkg::sum_width(WINDOW)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [amao_pkg::RAW_W-1:0]    i_raw_word,
    input  amao_pkg::t_cfg                i_cfg,
    output logic [SW-1:0]                 o_sum,
    output logic [amao_pkg::ANGLE_W-1:0]  o_angle
);

    logic [amao_pkg::VAL_W-1:0]   r_taps [WINDOW];
    logic [SW-1:0]                r_sum;
    logic [SW-1:0]                n_sum;
    logic [amao_pkg::ANGLE_W-1:0] r_angle;
    logic [amao_pkg::ANGLE_W-1:0] w_angle;
    logic [amao_pkg::VAL_W-1:0]   w_stored;

    assign w_angle = i_raw_word[amao_pkg::ANGLE_W-1:0];

    // Reversal wraps modulo 2^15 when the angle exceeds full scale.
    assign w_stored = i_cfg.reverse_direction
                    ? i_cfg.full_scale - amao_pkg::VAL_W'(w_angle)
                    : amao_pkg::VAL_W'(w_angle);

    assign n_sum = r_sum - SW'(r_taps[WINDOW-1]) + SW'(w_stored);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            for (int k = 0; k < WINDOW; k++) begin
                r_taps[k] <= '0;
            end
        end else if (i_load) begin
            r_sum     <= n_sum;
            r_taps[0] <= w_stored;
            for (int k = 1; k < WINDOW; k++) begin
                r_taps[k] <= r_taps[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_angle <= w_angle;
        end
    end

    assign o_sum   = r_sum;
    assign o_angle = r_angle;

endmodule

// ----- design/amao_mean.sv -----
// Window mean by reciprocal multiply (exact truncated division by WINDOW).
// Depends on amao_pkg.
module amao_mean #(
    parameter int WINDOW = amao_pkg::WINDOW_DEFAULT,
    localparam int SW    = amao_pkg::sum_width(WINDOW)
) (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic [SW-1:0]                 i_sum,
    input  logic [amao_pkg::ANGLE_W-1:0]  i_angle,
    output logic [amao_pkg::VAL_W-1:0]    o_mean,
    output logic [amao_pkg::ANGLE_W-1:0]  o_angle
);

    localparam int RecipL     = $clog2(WINDOW);
    localparam int RecipShift = SW + RecipL;
    localparam int PW         = 2 * SW + 1;
    // ceil(2^(SW+L) / WINDOW): exact floor division for any SW-bit sum
    localparam logic [SW:0] RecipM =
        (SW+1)'(((64'd1 << RecipShift) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    logic [PW-1:0]                w_product;
    logic [amao_pkg::VAL_W-1:0]   r_mean;
    logic [amao_pkg::ANGLE_W-1:0] r_angle;

    assign w_product = PW'(i_sum) * PW'(RecipM);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mean  <= w_product[RecipShift +: amao_pkg::VAL_W];
            r_angle <= i_angle;
        end
    end

    assign o_mean  = r_mean;
    assign o_angle = r_angle;

endmodule

// ----- design/amao_wrap.sv -----
// Offset add and single wrap, into the result register.
// Depends on amao_pkg.
module amao_wrap (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic [amao_pkg::VAL_W-1:0]    i_mean,
    input  logic [amao_pkg::ANGLE_W-1:0]  i_angle,
    input  amao_pkg::t_cfg                i_cfg,
    output logic [amao_pkg::ANGLE_W-1:0]  o_latest_angle,
    output logic [amao_pkg::VAL_W-1:0]    o_averaged_position
);

    logic [amao_pkg::VAL_W:0]     w_pos;
    logic [amao_pkg::VAL_W-1:0]   n_position;
    logic [amao_pkg::VAL_W-1:0]   r_position;
    logic [amao_pkg::ANGLE_W-1:0] r_angle;

    assign w_pos = (amao_pkg::VAL_W+1)'(i_mean) + (amao_pkg::VAL_W+1)'(i_cfg.angle_offset);

    always_comb begin
        n_position = w_pos[amao_pkg::VAL_W-1:0];
        if (w_pos > (amao_pkg::VAL_W+1)'(i_cfg.full_scale)) begin
            n_position = w_pos[amao_pkg::VAL_W-1:0] - i_cfg.wrap_modulo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_position <= n_position;
            r_angle    <= i_angle;
        end
    end

    assign o_latest_angle      = r_angle;
    assign o_averaged_position = r_position;

endmodule

// ----- design/angle_moving_average_offset_unit.sv -----
// Top level of the angle moving-average offset unit: config registers,
// three-stage valid/ready pipeline. Depends on amao_pkg, amao_window,
// amao_mean and amao_wrap.
//
//  channel   | direction | valid / ready          | payload
//  ----------+-----------+------------------------+--------------------------------------
//  input     | in        | i_in_valid / o_in_ready | i_raw_word[15:0]
//  result    | out       | o_out_valid / i_out_ready | o_latest_angle[13:0],
//            |           |                        | o_averaged_position[14:0]
//  config    | in        | i_cfg_valid / o_cfg_ready | i_cfg_index[7:0], i_cfg_data[15:0]
//
// One transfer per cycle sustained while the result side is ready. Three
// register stages (window/sum update, reciprocal multiply, offset and wrap)
// lie between an input transfer and its result.
// The running-sum register closes the only loop, so it sets the rate.
// Reset (synchronous, active low) clears the window, the sum, the pipeline
// valids and loads the register reset values; no clearing pass is needed.
// A stalled result holds the output register; bubbles ahead of it are
// squeezed out, so input ready drops only when all three stages are full.
// Config writes are always taken; indexes beyond the register list are ignored.
module angle_moving_average_offset_unit #(
    parameter int WINDOW = amao_pkg::WINDOW_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input samples
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [amao_pkg::RAW_W-1:0]        i_raw_word,
    // results
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [amao_pkg::ANGLE_W-1:0]      o_latest_angle,
    output logic [amao_pkg::VAL_W-1:0]        o_averaged_position,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [amao_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [amao_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int SW = amao_pkg::sum_width(WINDOW);
    localparam logic [SW-1:0] SumMax = SW'(WINDOW * amao_pkg::ENTRY_MAX);

    amao_pkg::t_cfg r_cfg;

    // Pipeline occupancy: r_v1 window/sum stage, r_v2 mean stage, r_vo result.
    logic r_v1;
    logic r_v2;
    logic r_vo;
    logic w_adv_out;
    logic w_adv2;
    logic w_adv1;
    logic w_in_xfer;
    logic w_cfg_xfer;

    logic [SW-1:0]                w_sum;
    logic [amao_pkg::ANGLE_W-1:0] w_angle1;
    logic [amao_pkg::VAL_W-1:0]   w_mean;
    logic [amao_pkg::ANGLE_W-1:0] w_angle2;

    // A stage may load when it is empty or its content moves on this cycle.
    assign w_adv_out = !r_vo || i_out_ready;
    assign w_adv2    = !r_v2 || w_adv_out;
    assign w_adv1    = !r_v1 || w_adv2;

    assign o_in_ready  = w_adv1;
    assign w_in_xfer   = i_in_valid && w_adv1;
    assign o_out_valid = r_vo;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_xfer  = i_cfg_valid;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reverse_direction <= 1'b0;
            r_cfg.full_scale        <= amao_pkg::FULLSCALE_RESET;
            r_cfg.angle_offset      <= '0;
            r_cfg.wrap_modulo       <= amao_pkg::WRAP_RESET;
        end else if (w_cfg_xfer) begin
            unique case (i_cfg_index)
                amao_pkg::CFG_REVERSE: begin
                    r_cfg.reverse_direction <= i_cfg_data[0];
                end
                amao_pkg::CFG_FULLSCALE: begin
                    r_cfg.full_scale <= i_cfg_data[amao_pkg::VAL_W-1:0];
                end
                amao_pkg::CFG_OFFSET: begin
                    r_cfg.angle_offset <= i_cfg_data[amao_pkg::ANGLE_W-1:0];
                end
                amao_pkg::CFG_WRAP: begin
                    r_cfg.wrap_modulo <= i_cfg_data[amao_pkg::VAL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= i_in_valid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
            if (w_adv_out) begin
                r_vo <= r_v2;
            end
        end
    end

    // Window update happens only on an input transfer, so the sum sees
    // each sample exactly once.
    amao_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_in_xfer),
        .i_raw_word (i_raw_word),
        .i_cfg      (r_cfg),
        .o_sum      (w_sum),
        .o_angle    (w_angle1)
    );

    amao_mean #(
        .WINDOW (WINDOW)
    ) u_mean (
        .i_clk   (i_clk),
        .i_load  (w_adv2 && r_v1),
        .i_sum   (w_sum),
        .i_angle (w_angle1),
        .o_mean  (w_mean),
        .o_angle (w_angle2)
    );

    amao_wrap u_wrap (
        .i_clk               (i_clk),
        .i_load              (w_adv_out && r_v2),
        .i_mean              (w_mean),
        .i_angle             (w_angle2),
        .i_cfg               (r_cfg),
        .o_latest_angle      (o_latest_angle),
        .o_averaged_position (o_averaged_position)
    );

`ifndef NO_ASSERTIONS
    // Running sum never exceeds a full window of maximal entries.
    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sum <= SumMax)
        else $error("running sum out of range");

    // An accepted sample occupies the first stage on the next cycle.
    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> r_v1)
        else $error("accepted sample lost at first stage");

    // A stalled result is never overwritten by the stage behind it.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && !i_out_ready) |=> r_vo)
        else $error("pending result dropped");

    // With all stages full and the output stalled, no input is taken.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_vo && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while pipeline is full");
`endif

endmodule
